// ===== src/bwf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, sizes and codes for the message bad-word filter.
// Used by every module of the block; depends on nothing.
package bwf_pkg;

	localparam int NUM_PATTERNS = 256;
	localparam int MAX_LEN      = 16;
	localparam int SLOT_W       = $clog2(NUM_PATTERNS);
	localparam int POS_W        = $clog2(MAX_LEN);
	localparam int LEN_W        = $clog2(MAX_LEN + 1);
	localparam int CNT_W        = $clog2(NUM_PATTERNS + 1);
	localparam logic [15:0] SCRIPT_GAP = 16'd255;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_MSG  = 1'b1;

	localparam logic [1:0] REASON_NONE   = 2'd0;
	localparam logic [1:0] REASON_SCRIPT = 2'd1;
	localparam logic [1:0] REASON_RAW    = 2'd2;
	localparam logic [1:0] REASON_CLEAN  = 2'd3;

	localparam logic [1:0] CFG_LIMIT = 2'd0;
	localparam logic [1:0] CFG_CLEAN = 2'd1;
	localparam logic [1:0] CFG_COUNT = 2'd2;
	localparam logic [1:0] CFG_EXTRA = 2'd3;

	typedef logic [15:0] chr_t;
	typedef chr_t [MAX_LEN-1:0] row_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  pos;
		chr_t              code;
		logic              last;
	} pwr_t;

	function automatic logic is_std_excepted(input chr_t c);
		logic r;
		r = (c == 16'h0D) || (c == 16'h0A) || (c == 16'h20) || (c == 16'h2E) ||
			(c == 16'h2C) || (c == 16'h3C) || (c == 16'h3E) || (c == 16'h2F) ||
			(c == 16'h3F) || (c == 16'h3B) || (c == 16'h3A) || (c == 16'h27) ||
			(c == 16'h22) || (c == 16'h5C) || (c == 16'h5D) || (c == 16'h5B) ||
			(c == 16'h7D) || (c == 16'h7B) || (c == 16'h60) || (c == 16'h2D) ||
			(c == 16'h3D) || (c == 16'h7E) || (c == 16'h21) || (c == 16'h40) ||
			(c == 16'h23) || (c == 16'h24) || (c == 16'h25) || (c == 16'h5E) ||
			(c == 16'h26) || (c == 16'h2A) || (c == 16'h28) || (c == 16'h29) ||
			(c == 16'h5F) || (c == 16'h2B) || (c == 16'h00) ||
			((c >= 16'h30) && (c <= 16'h39));
		return r;
	endfunction

endpackage

// ===== src/message_bad_word_filter_core.sv =====
`timescale 1ns / 1ps
// Message bad-word filter top level: control sequencer, windows, counters.
// Uses bwf_pkg, bwf_pat_mem and bwf_match.
//
// A load item writes the pattern table and busy stays low. A message item
// holds busy while it sweeps the active patterns (pattern_count, at most
// 256), twice when the character is alphanumeric; the item that ends a
// message then passes a final state, after which done pulses for one cycle
// with spam, reason and lang_changes. The pattern table yields one pattern
// row per cycle to a single compare unit.
// The receiver cannot stall: done must be sampled in the cycle it is high.
module message_bad_word_filter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [7:0]  pattern_slot,
	input  logic [3:0]  char_pos,
	input  logic [15:0] char_code,
	input  logic        is_alnum,
	input  logic        end_mark,
	output logic        done,
	output logic        spam,
	output logic [1:0]  reason,
	output logic [15:0] lang_changes,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_FIN} state_t;

	state_t                    state_q;
	logic [15:0]               limit_q;
	logic                      clean_en_q;
	logic [8:0]                pcount_q;
	logic [15:0]               extra_q;

	bwf_pkg::row_t             raw_win_q;
	bwf_pkg::row_t             clean_win_q;
	logic [bwf_pkg::LEN_W-1:0] raw_fill_q;
	logic [bwf_pkg::LEN_W-1:0] clean_fill_q;
	logic [15:0]               prev_q;
	logic [15:0]               count_q;
	logic                      raw_hit_q;
	logic                      clean_hit_q;
	logic                      alnum_q;
	logic                      last_q;
	logic                      pass_q;
	logic [bwf_pkg::CNT_W-1:0] addr_q;
	logic                      rd_v_s1;
	logic                      pass_s1;
	logic                      done_q;
	logic                      spam_q;
	logic [1:0]                reason_q;
	logic [15:0]               changes_q;

	logic                      accept;
	logic [bwf_pkg::CNT_W-1:0] n_act;
	logic                      rd_en;
	bwf_pkg::pwr_t             wr;
	bwf_pkg::row_t             row_s1;
	logic [bwf_pkg::LEN_W-1:0] len_s1;
	logic                      hit;
	logic                      excepted;
	logic [15:0]               diff;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign n_act = (pcount_q > 9'(bwf_pkg::NUM_PATTERNS)) ?
		bwf_pkg::CNT_W'(bwf_pkg::NUM_PATTERNS) : bwf_pkg::CNT_W'(pcount_q);
	assign rd_en = (state_q == ST_SWEEP) && (addr_q < n_act);

	always_comb begin
		wr.en   = accept && (opcode == bwf_pkg::OP_LOAD) &&
			(32'(pattern_slot) < bwf_pkg::NUM_PATTERNS) &&
			(32'(char_pos) < bwf_pkg::MAX_LEN);
		wr.slot = bwf_pkg::SLOT_W'(pattern_slot);
		wr.pos  = bwf_pkg::POS_W'(char_pos);
		wr.code = char_code;
		wr.last = end_mark;
	end

	assign excepted = bwf_pkg::is_std_excepted(char_code) || (char_code == extra_q);
	assign diff     = (prev_q > char_code) ? (prev_q - char_code) : (char_code - prev_q);

	bwf_pat_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.raddr  (addr_q[bwf_pkg::SLOT_W-1:0]),
		.row_s1 (row_s1),
		.len_s1 (len_s1)
	);

	bwf_match u_match (
		.row  (row_s1),
		.len  (len_s1),
		.win  (pass_s1 ? clean_win_q : raw_win_q),
		.fill (pass_s1 ? clean_fill_q : raw_fill_q),
		.hit  (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= 16'd5;
			clean_en_q <= 1'b1;
			pcount_q   <= '0;
			extra_q    <= 16'd8470;
		end else if (cfg_we) begin
			case (cfg_idx)
				bwf_pkg::CFG_LIMIT: limit_q    <= cfg_data;
				bwf_pkg::CFG_CLEAN: clean_en_q <= cfg_data[0];
				bwf_pkg::CFG_COUNT: pcount_q   <= cfg_data[8:0];
				bwf_pkg::CFG_EXTRA: extra_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// windows carry no reset: the fill counts guard them
	always_ff @(posedge clk) begin
		if (accept && (opcode == bwf_pkg::OP_MSG)) begin
			raw_win_q <= {raw_win_q[bwf_pkg::MAX_LEN-2:0], char_code};
			if (is_alnum) begin
				clean_win_q <= {clean_win_q[bwf_pkg::MAX_LEN-2:0], char_code};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			raw_fill_q   <= '0;
			clean_fill_q <= '0;
			prev_q       <= '0;
			count_q      <= '0;
			raw_hit_q    <= 1'b0;
			clean_hit_q  <= 1'b0;
			alnum_q      <= 1'b0;
			last_q       <= 1'b0;
			pass_q       <= 1'b0;
			addr_q       <= '0;
			rd_v_s1      <= 1'b0;
			pass_s1      <= 1'b0;
			done_q       <= 1'b0;
			spam_q       <= 1'b0;
			reason_q     <= bwf_pkg::REASON_NONE;
			changes_q    <= '0;
		end else begin
			done_q  <= (state_q == ST_FIN);
			rd_v_s1 <= rd_en;
			pass_s1 <= pass_q;
			if (rd_en) begin
				addr_q <= addr_q + 1'b1;
			end
			if (rd_v_s1 && hit) begin
				if (pass_s1) begin
					clean_hit_q <= 1'b1;
				end else begin
					raw_hit_q <= 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (opcode == bwf_pkg::OP_MSG)) begin
						if (!excepted) begin
							if ((prev_q != '0) && (diff > bwf_pkg::SCRIPT_GAP) &&
								(count_q != 16'hFFFF)) begin
								count_q <= count_q + 1'b1;
							end
							prev_q <= char_code;
						end
						if (raw_fill_q < bwf_pkg::LEN_W'(bwf_pkg::MAX_LEN)) begin
							raw_fill_q <= raw_fill_q + 1'b1;
						end
						if (is_alnum &&
							(clean_fill_q < bwf_pkg::LEN_W'(bwf_pkg::MAX_LEN))) begin
							clean_fill_q <= clean_fill_q + 1'b1;
						end
						alnum_q <= is_alnum;
						last_q  <= end_mark;
						pass_q  <= 1'b0;
						addr_q  <= '0;
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					// the last row's compare lands in this same cycle
					if (!rd_en) begin
						if (!pass_q && alnum_q) begin
							pass_q <= 1'b1;
							addr_q <= '0;
						end else if (last_q) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FIN: begin
					changes_q <= count_q;
					if ((limit_q != '0) && (count_q >= limit_q)) begin
						spam_q   <= 1'b1;
						reason_q <= bwf_pkg::REASON_SCRIPT;
					end else if (raw_hit_q) begin
						spam_q   <= 1'b1;
						reason_q <= bwf_pkg::REASON_RAW;
					end else if (clean_en_q && clean_hit_q) begin
						spam_q   <= 1'b1;
						reason_q <= bwf_pkg::REASON_CLEAN;
					end else begin
						spam_q   <= 1'b0;
						reason_q <= bwf_pkg::REASON_NONE;
					end
					// drop all per-message state
					raw_fill_q   <= '0;
					clean_fill_q <= '0;
					prev_q       <= '0;
					count_q      <= '0;
					raw_hit_q    <= 1'b0;
					clean_hit_q  <= 1'b0;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done         = done_q;
	assign spam         = spam_q;
	assign reason       = reason_q;
	assign lang_changes = changes_q;

endmodule

// ===== src/bwf_pat_mem.sv =====
`timescale 1ns / 1ps
// Pattern table: one row of characters and one length per slot.
// Uses bwf_pkg; lengths read as zero until their slot is ended by a load.
module bwf_pat_mem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bwf_pkg::pwr_t             wr,
	input  logic [bwf_pkg::SLOT_W-1:0] raddr,
	output bwf_pkg::row_t             row_s1,
	output logic [bwf_pkg::LEN_W-1:0] len_s1
);

	bwf_pkg::row_t                  chars_q [bwf_pkg::NUM_PATTERNS];
	logic [bwf_pkg::LEN_W-1:0]      lens_q  [bwf_pkg::NUM_PATTERNS];
	logic [bwf_pkg::NUM_PATTERNS-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			chars_q[wr.slot][wr.pos] <= wr.code;
			if (wr.last) begin
				lens_q[wr.slot] <= bwf_pkg::LEN_W'({1'b0, wr.pos} + 1'b1);
			end
		end
		row_s1 <= chars_q[raddr];
		len_s1 <= vld_q[raddr] ? lens_q[raddr] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en && wr.last) begin
			vld_q[wr.slot] <= 1'b1;
		end
	end

endmodule

// ===== src/bwf_match.sv =====
`timescale 1ns / 1ps
// Compare unit: one pattern row against the newest characters of a window.
// Uses bwf_pkg; shared by the raw and the alphanumeric-only pass.
module bwf_match (
	input  bwf_pkg::row_t             row,
	input  logic [bwf_pkg::LEN_W-1:0] len,
	input  bwf_pkg::row_t             win,
	input  logic [bwf_pkg::LEN_W-1:0] fill,
	output logic                      hit
);

	logic [bwf_pkg::MAX_LEN-1:0] eq;

	always_comb begin
		for (int j = 0; j < bwf_pkg::MAX_LEN; j++) begin
			logic [bwf_pkg::LEN_W-1:0] idx;
			idx = len - 1'b1 - bwf_pkg::LEN_W'(j);
			// pattern position j lines up with window entry len-1-j
			if (bwf_pkg::LEN_W'(j) < len) begin
				eq[j] = (row[j] == win[idx[bwf_pkg::POS_W-1:0]]);
			end else begin
				eq[j] = 1'b1;
			end
		end
		hit = (len != '0) && (len <= fill) && (&eq);
	end

endmodule

// ===== src/bwf_check.sv =====
`timescale 1ns / 1ps
// Port-level checks for the message bad-word filter, bound to the top level.
// Uses bwf_pkg for the reason codes.
module bwf_check (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       spam,
	input logic [1:0] reason
);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(busy))
		else $error("result without an item in work");

	a_busy_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without start");

	a_spam_reason: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (spam == (reason != bwf_pkg::REASON_NONE)))
		else $error("spam and reason disagree");

endmodule

bind message_bad_word_filter_core bwf_check u_bwf_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.spam   (spam),
	.reason (reason)
);
